// ===== hdl/keyed_slot_table_top_defines.svh =====
// ---------------------------------------------------------------------------
// keyed_slot_table_top_defines.svh
// Assertion macros for the keyed slot table. They expand to nothing when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_TOP_DEFINES_SVH
`define KEYED_SLOT_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds
`define KST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: cons must hold in the cycle after ante
`define KST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KST_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/kst_pkg.sv =====
// ---------------------------------------------------------------------------
// kst_pkg
// Sizes, codes and shared types of the keyed slot table.
// ---------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

   // Table geometry
   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Field widths
   localparam int KEY_W = 16;
   localparam int VAL_W = 16;

   // Request actions
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_UPDATE = 2'd2
   } kst_action_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } kst_status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } kst_state_type;

   // Write side of the slot store
   typedef struct packed {
      logic             key_en;
      logic             val_en;
      logic [IDX_W-1:0] addr;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
   } kst_wr_type;

   // Read data of the slot store
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
   } kst_rd_type;

endpackage

`default_nettype wire

// ===== hdl/kst_store.sv =====
// ---------------------------------------------------------------------------
// kst_store
// Key and value memories of the slot table: one registered read port and
// one write port with separate enables for key and value.
// ---------------------------------------------------------------------------
`default_nettype none

module kst_store (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [kst_pkg::IDX_W-1:0] rd_addr,
   output kst_pkg::kst_rd_type          rd_data,
   input  wire kst_pkg::kst_wr_type     wr
);
   import kst_pkg::*;

   logic [KEY_W-1:0] key_mem [SLOTS];
   logic [VAL_W-1:0] val_mem [SLOTS];
   kst_rd_type       rd_data_ff;

   // Write key and value independently
   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (wr.val_en) begin
         val_mem[wr.addr] <= wr.val;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.key <= key_mem[rd_addr];
         rd_data_ff.val <= val_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/keyed_slot_table_top.sv =====
// ---------------------------------------------------------------------------
// keyed_slot_table_top
// Associative slot table with first-free allocation: insert, remove and
// update of keyed entries, one request at a time.
// ---------------------------------------------------------------------------
//
//   channel   direction  tdata fields (lsb first)                      width
//   req_*     in         action, entry_key, new_value                   40
//   rsp_*     out        status, slot_index, slot_value, free_slots     32
//
// Scan: a request walks the slots from slot 0, one slot per cycle through
// the store's read port, and stops at the first hit. The unused action
// code skips the walk.
// Reset: synchronous; all slots free, free count SLOTS, no clearing pass.
// Stalls: the response register holds a finished beat while the next request
// is accepted and scanned; only the write-back waits for it to drain.
// ---------------------------------------------------------------------------
`default_nettype none
`include "keyed_slot_table_top_defines.svh"

module keyed_slot_table_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] action, [17:2] entry_key, [33:18] new_value, [39:34] zero
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [5:2] slot_index, [21:6] slot_value, [26:22] free_slots,
   // [31:27] zero
   output logic [31:0]      rsp_tdata
);
   import kst_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Control registers
   kst_state_type    state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] probe_ff, probe_in;
   logic             probe_on_ff, probe_on_in;
   logic             found_ff, found_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;

   // Payload registers
   logic [1:0]       act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] nval_ff, nval_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [31:0]      rsp_tdata_ff, rsp_tdata_in;

   // Store interface
   logic             rd_en;
   kst_rd_type       rd_data;
   kst_wr_type       wr;

   // Probe evaluation and response fields
   logic             probe_valid;
   logic             probe_hit;
   logic             last_probe;
   logic             finish_go;
   logic [1:0]       out_status;
   logic [3:0]       out_idx;
   logic [VAL_W-1:0] out_val;
   logic [31:0]      hit_wide;
   logic [31:0]      count_wide;

   kst_store u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // Judge the slot whose data returns from the store this cycle
   assign probe_valid = valid_ff[probe_ff];
   assign probe_hit   = (act_ff == ACT_INSERT) ? !probe_valid
                                               : (probe_valid && (rd_data.key == key_ff));
   assign last_probe  = (probe_ff == LAST_IDX);
   assign hit_wide    = 32'(hit_ff);
   assign count_wide  = 32'(count_in);

   // Next state, scan control and write-back
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      probe_in      = probe_ff;
      probe_on_in   = probe_on_ff;
      found_in      = found_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      act_in        = act_ff;
      key_in        = key_ff;
      nval_in       = nval_ff;
      hit_in        = hit_ff;
      val_in        = val_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = (state_ff == S_IDLE);
      rd_en         = 1'b0;
      finish_go     = 1'b0;
      wr            = '0;
      wr.addr       = hit_ff;
      wr.key        = key_ff;
      out_status    = ST_MISSING;
      out_idx       = '0;
      out_val       = '0;

      case (state_ff)
         S_IDLE: begin
            // Capture the request and, for a known action, start the walk at slot 0
            if (req_tvalid) begin
               act_in      = req_tdata[1:0];
               key_in      = req_tdata[17:2];
               nval_in     = req_tdata[33:18];
               addr_in     = '0;
               probe_on_in = 1'b0;
               found_in    = 1'b0;
               if (req_tdata[1:0] == ACT_INSERT || req_tdata[1:0] == ACT_REMOVE ||
                   req_tdata[1:0] == ACT_UPDATE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            rd_en = 1'b1;
            if (probe_on_ff && probe_hit) begin
               // Stop at the lowest hit and keep the value read there
               found_in = 1'b1;
               hit_in   = probe_ff;
               val_in   = rd_data.val;
               state_in = S_FINISH;
            end else if (probe_on_ff && last_probe) begin
               state_in = S_FINISH;
            end else begin
               // Advance the read address; the probe holds the previous read address
               probe_in    = addr_ff;
               probe_on_in = 1'b1;
               if (addr_ff != LAST_IDX) begin
                  addr_in = addr_ff + 1'b1;
               end
            end
         end
         S_FINISH: begin
            // Write back once the response register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               finish_go = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Apply the action and build the response beat
      if (finish_go) begin
         if (found_ff) begin
            case (act_ff)
               ACT_INSERT: begin
                  wr.key_en        = 1'b1;
                  wr.val_en        = 1'b1;
                  wr.val           = '0;
                  valid_in[hit_ff] = 1'b1;
                  count_in         = count_ff - 1'b1;
                  out_val          = '0;
               end
               ACT_REMOVE: begin
                  valid_in[hit_ff] = 1'b0;
                  count_in         = count_ff + 1'b1;
                  out_val          = val_ff;
               end
               ACT_UPDATE: begin
                  wr.val_en = 1'b1;
                  wr.val    = nval_ff;
                  out_val   = nval_ff;
               end
               default: begin
                  out_val = '0;
               end
            endcase
            out_status = ST_DONE;
            out_idx    = hit_wide[3:0];
         end else if (act_ff == ACT_INSERT) begin
            out_status = ST_FULL;
         end else begin
            out_status = ST_MISSING;
         end
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {5'b0, count_wide[4:0], out_val, out_idx, out_status};
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         addr_ff       <= '0;
         probe_ff      <= '0;
         probe_on_ff   <= 1'b0;
         found_ff      <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= CNT_W'(SLOTS);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         probe_ff      <= probe_in;
         probe_on_ff   <= probe_on_in;
         found_ff      <= found_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      nval_ff      <= nval_in;
      hit_ff       <= hit_in;
      val_ff       <= val_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Free count tracks the valid bits between requests
   `KST_ASSERT_IMP(a_count_matches, clock, reset, state_ff == S_IDLE,
      count_ff == CNT_W'(SLOTS - $countones(valid_ff)), "free count out of step")

   // A response beat only appears after a write-back
   `KST_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_tvalid_ff),
      $past(state_ff) == S_FINISH, "response loaded outside write-back")

   // The store is written only while no scan reads it
   `KST_ASSERT_IMP(a_no_rw_overlap, clock, reset, wr.key_en || wr.val_en,
      !rd_en && state_ff == S_FINISH, "store write overlaps a scan")

   // An accepted request leaves the idle state
   `KST_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready,
      state_ff == S_SCAN || state_ff == S_FINISH, "accepted request not started")

endmodule

`default_nettype wire
